/* rtl/core/srml_pkg.sv */
`default_nettype none

package srml_pkg;

  // Command codes carried by an input item.
  localparam logic [1:0] CMD_ROW_WRITE  = 2'd0;
  localparam logic [1:0] CMD_CELL_WRITE = 2'd1;
  localparam logic [1:0] CMD_QUERY      = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT  = 1'b0;
  localparam logic REG_CELL_COUNT = 1'b1;

  localparam int ROW_COUNT_W  = 11;
  localparam int CELL_COUNT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int ROW_W        = 10;
  localparam int SLOT_W       = 12;
  localparam int COL_W        = 16;
  localparam int VALUE_W      = 64;

  typedef struct packed {
    logic [1:0]         command;
    logic [ROW_W-1:0]   row;
    logic               row_is_empty;
    logic [SLOT_W-1:0]  cell_index;
    logic [COL_W-1:0]   column;
    logic [VALUE_W-1:0] cell_data;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_ROW_SCAN,
    ST_CELL_SCAN,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic load_query;
    logic head_read;
    logic head_setup;
    logic row_scan;
    logic cell_scan;
    logic hit;
    logic miss;
    logic respond;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic in_range;
    logic head_empty;
    logic row_end;
    logic cell_eq;
    logic cell_stop;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/srml_ram.sv */
`default_nettype none

module srml_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/srml_ctrl.sv */
`default_nettype none

module srml_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire srml_pkg::status_t status,
  output srml_pkg::ctrl_t        ctrl
);

  srml_pkg::state_t state;
  srml_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      srml_pkg::ST_IDLE: begin
        ctrl.idle = 1'b1;
        if (in_valid && status.is_query) begin
          ctrl.load_query = 1'b1;
          state_next      = srml_pkg::ST_HEAD_RD;
        end
      end
      srml_pkg::ST_HEAD_RD: begin
        if (!status.in_range) begin
          ctrl.miss  = 1'b1;
          state_next = srml_pkg::ST_RESP;
        end else begin
          ctrl.head_read = 1'b1;
          state_next     = srml_pkg::ST_HEAD_CHK;
        end
      end
      srml_pkg::ST_HEAD_CHK: begin
        if (status.head_empty) begin
          ctrl.miss  = 1'b1;
          state_next = srml_pkg::ST_RESP;
        end else begin
          ctrl.head_setup = 1'b1;
          state_next      = srml_pkg::ST_ROW_SCAN;
        end
      end
      srml_pkg::ST_ROW_SCAN: begin
        ctrl.row_scan = 1'b1;
        if (status.row_end) begin
          state_next = srml_pkg::ST_CELL_SCAN;
        end
      end
      srml_pkg::ST_CELL_SCAN: begin
        ctrl.cell_scan = 1'b1;
        if (status.cell_eq) begin
          ctrl.hit   = 1'b1;
          state_next = srml_pkg::ST_RESP;
        end else if (status.cell_stop) begin
          ctrl.miss  = 1'b1;
          state_next = srml_pkg::ST_RESP;
        end
      end
      srml_pkg::ST_RESP: begin
        if (status.out_free) begin
          ctrl.respond = 1'b1;
          state_next   = srml_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srml_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/srml_dp.sv */
`default_nettype none

module srml_dp #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_CELLS   = 4096,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [srml_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  input  wire srml_pkg::in_t                   in_data,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output srml_pkg::out_t                       out_data,
  input  wire srml_pkg::ctrl_t                 ctrl,
  output srml_pkg::status_t                    status
);

  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELL_AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W  = $clog2(MAX_CELLS + 1);
  // Row and cell counters are wide enough for both the register and the depth.
  localparam int RW   = (RCNT_W > srml_pkg::ROW_COUNT_W) ? RCNT_W : srml_pkg::ROW_COUNT_W;
  localparam int CW   = (CCNT_W > srml_pkg::CELL_COUNT_W) ? CCNT_W : srml_pkg::CELL_COUNT_W;
  localparam int CMPW = (COLUMN_BITS > srml_pkg::COL_W) ? COLUMN_BITS : srml_pkg::COL_W;
  localparam int ROW_DW  = srml_pkg::SLOT_W + 1;
  localparam int CELL_DW = COLUMN_BITS + srml_pkg::VALUE_W;

  logic [srml_pkg::ROW_COUNT_W-1:0]  row_count;
  logic [srml_pkg::CELL_COUNT_W-1:0] cell_count;

  logic [srml_pkg::ROW_W-1:0]   q_row;
  logic [srml_pkg::COL_W-1:0]   q_col;
  logic [srml_pkg::SLOT_W-1:0]  start_r;
  logic [RW-1:0]                k;
  logic                         row_vld;
  logic [CW-1:0]                end_r;
  logic [CW-1:0]                j;
  logic                         cell_vld;
  logic                         res_found;
  logic [srml_pkg::VALUE_W-1:0] res_value;

  logic [RW-1:0]      rows;
  logic [CW-1:0]      cells;
  logic [RW-1:0]      q_row_ext;
  logic [RW-1:0]      in_row_ext;
  logic [CW-1:0]      in_slot_ext;
  logic [CMPW-1:0]    in_col_ext;
  logic [CMPW-1:0]    q_col_ext;
  logic [CMPW-1:0]    stored_col;
  logic               take;
  logic               row_we;
  logic               cell_we;
  logic [ROW_AW-1:0]  row_raddr;
  logic [ROW_DW-1:0]  row_rdata;
  logic [CELL_DW-1:0] cell_wdata;
  logic [CELL_DW-1:0] cell_rdata;
  logic               row_issue;
  logic               row_hit;
  logic               row_exhaust;
  logic               cell_issue;
  logic               cell_exhaust;
  logic               cell_gt;

  always_comb begin
    rows  = (RW'(row_count) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(row_count);
    cells = (CW'(cell_count) > CW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(cell_count);
    q_row_ext   = RW'(q_row);
    in_row_ext  = RW'(in_data.row);
    in_slot_ext = CW'(in_data.cell_index);
    in_col_ext  = CMPW'(in_data.column);
    q_col_ext   = CMPW'(q_col);
    stored_col  = CMPW'(cell_rdata[CELL_DW-1:srml_pkg::VALUE_W]);

    take    = in_valid && ctrl.idle;
    row_we  = take && (in_data.command == srml_pkg::CMD_ROW_WRITE)
              && (in_row_ext < RW'(MAX_ROWS));
    cell_we = take && (in_data.command == srml_pkg::CMD_CELL_WRITE)
              && (in_slot_ext < CW'(MAX_CELLS));
    cell_wdata = {in_col_ext[COLUMN_BITS-1:0], in_data.cell_data};

    row_raddr = ctrl.head_read ? q_row_ext[ROW_AW-1:0] : k[ROW_AW-1:0];

    // Reads are issued one per cycle; the valid flag marks that the
    // registered read data belongs to an issued address.
    row_issue    = k < rows;
    row_hit      = row_vld && !row_rdata[ROW_DW-1];
    row_exhaust  = !row_vld && !row_issue;
    cell_issue   = (j < end_r) && (j < CW'(MAX_CELLS));
    cell_exhaust = !cell_vld && !cell_issue;
    cell_gt      = cell_vld && (stored_col > q_col_ext);

    status.is_query   = in_data.command == srml_pkg::CMD_QUERY;
    status.in_range   = q_row_ext < rows;
    status.head_empty = row_rdata[ROW_DW-1];
    status.row_end    = row_hit || row_exhaust;
    status.cell_eq    = cell_vld && (stored_col == q_col_ext);
    status.cell_stop  = cell_gt || cell_exhaust;
    status.out_free   = !out_valid || !out_stall;
  end

  srml_ram #(
    .WIDTH  (ROW_DW),
    .DEPTH  (MAX_ROWS),
    .ADDR_W (ROW_AW)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (in_row_ext[ROW_AW-1:0]),
    .wdata ({in_data.row_is_empty, in_data.cell_index}),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  srml_ram #(
    .WIDTH  (CELL_DW),
    .DEPTH  (MAX_CELLS),
    .ADDR_W (CELL_AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (in_slot_ext[CELL_AW-1:0]),
    .wdata (cell_wdata),
    .raddr (j[CELL_AW-1:0]),
    .rdata (cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      cell_count <= '0;
      row_vld    <= 1'b0;
      cell_vld   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          srml_pkg::REG_ROW_COUNT:  row_count  <= cfg_data[srml_pkg::ROW_COUNT_W-1:0];
          srml_pkg::REG_CELL_COUNT: cell_count <= cfg_data[srml_pkg::CELL_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.head_setup) begin
        row_vld <= 1'b0;
      end else if (ctrl.row_scan) begin
        row_vld <= row_issue;
      end
      if (ctrl.row_scan && status.row_end) begin
        cell_vld <= 1'b0;
      end else if (ctrl.cell_scan) begin
        cell_vld <= cell_issue;
      end
      if (ctrl.respond) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_query) begin
      q_row <= in_data.row;
      q_col <= in_data.column;
    end
    if (ctrl.head_setup) begin
      start_r <= row_rdata[srml_pkg::SLOT_W-1:0];
      k       <= q_row_ext + RW'(1);
    end else if (ctrl.row_scan && row_issue) begin
      k <= k + RW'(1);
    end
    if (ctrl.row_scan && status.row_end) begin
      // The row ends where the next non-empty row starts, else at the cell count.
      end_r <= row_hit ? CW'(row_rdata[srml_pkg::SLOT_W-1:0]) : cells;
      j     <= CW'(start_r);
    end else if (ctrl.cell_scan && cell_issue) begin
      j <= j + CW'(1);
    end
    if (ctrl.hit) begin
      res_found <= 1'b1;
      res_value <= cell_rdata[srml_pkg::VALUE_W-1:0];
    end else if (ctrl.miss) begin
      res_found <= 1'b0;
      res_value <= '0;
    end
    if (ctrl.respond) begin
      out_data.found <= res_found;
      out_data.value <= res_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sparse_row_matrix_lookup.sv */
`default_nettype none

// Channel  Signals                      Direction  Moves
// in       in_valid/in_stall/in_data    input      one command item
// out      out_valid/out_stall/out_data output     one query result item
// cfg      cfg_we/cfg_index/cfg_data    input      register write, no wait
//
// A write item gives no result. A query steps through a range check, a read of the queried
// row's head, a scan of the rows after it for the next non-empty row, and a scan of the
// row's cells in column order, one read per cycle on each memory, before its response step.
// An out-of-range or empty row goes straight from its check to the response step.
// Reset is synchronous and clears the counts and valid flags; memories and data are not cleared.
// A result waiting under out_stall holds the next query at its response step.

module sparse_row_matrix_lookup #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_CELLS   = 4096,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [srml_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire srml_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output srml_pkg::out_t                       out_data
);

  srml_pkg::ctrl_t   ctrl;
  srml_pkg::status_t status;

  assign in_stall = !ctrl.idle;

  srml_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  srml_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_CELLS   (MAX_CELLS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctrl      (ctrl),
    .status    (status)
  );

  // A new result appears only from the response step.
  a_result_from_respond: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.respond))
    else $error("result appeared without a response step");

  // No item is taken while a query is still scanning.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    (ctrl.row_scan || ctrl.cell_scan || ctrl.respond) |-> in_stall)
    else $error("item accepted during a query");

  // A verdict moves the query to its response and ends the scan.
  a_verdict_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (ctrl.hit || ctrl.miss) |=> !ctrl.row_scan && !ctrl.cell_scan && !ctrl.idle)
    else $error("scan continued after a verdict");

endmodule

`default_nettype wire

/* bench/sparse_row_matrix_lookup_test.sv */
`timescale 1ns / 1ps

module sparse_row_matrix_lookup_test;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ROW_DEPTH = 1024;
  localparam int CELL_DEPTH = 4096;
  localparam int QUIET_CYCLES = 8;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [srml_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  srml_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  srml_pkg::out_t out_data;

  int send_gap_pct = 16;
  int recv_stall_pct = 47;
  int items_issued = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Shadow copy of the matrix and the two registers.
  logic [srml_pkg::SLOT_W-1:0] shadow_row_start[ROW_DEPTH];
  bit shadow_row_void[ROW_DEPTH];
  bit shadow_row_known[ROW_DEPTH];
  logic [srml_pkg::COL_W-1:0] shadow_cell_col[CELL_DEPTH];
  logic [srml_pkg::VALUE_W-1:0] shadow_cell_val[CELL_DEPTH];
  bit shadow_cell_known[CELL_DEPTH];
  int unsigned shadow_row_count = 0;
  int unsigned shadow_cell_count = 0;

  // Layout of the matrix loaded by the current random phase; -1 marks an empty row.
  int layout_first[ROW_DEPTH];
  int layout_len[ROW_DEPTH];

  srml_pkg::out_t pending_lookups[$];
  srml_pkg::out_t oldest_answer;

  sparse_row_matrix_lookup uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Returns 0 when the lookup would touch a store entry that was never written.
  function automatic bit lookup_element(input logic [srml_pkg::ROW_W-1:0] r,
                                        input logic [srml_pkg::COL_W-1:0] col,
                                        output srml_pkg::out_t answer);
    int rows_lim;
    int cells_lim;
    int stop;
    int k;
    rows_lim = (shadow_row_count > ROW_DEPTH) ? ROW_DEPTH : int'(shadow_row_count);
    cells_lim = (shadow_cell_count > CELL_DEPTH) ? CELL_DEPTH : int'(shadow_cell_count);
    answer = '0;
    if (int'(r) >= rows_lim) return 1'b1;
    if (!shadow_row_known[r]) return 1'b0;
    if (shadow_row_void[r]) return 1'b1;
    // With only empty rows after this one, the row runs to the cell count.
    stop = cells_lim;
    for (k = int'(r) + 1; k < rows_lim; k++) begin
      if (!shadow_row_known[k]) return 1'b0;
      if (!shadow_row_void[k]) begin
        stop = int'(shadow_row_start[k]);
        break;
      end
    end
    for (k = int'(shadow_row_start[r]); k < stop && k < CELL_DEPTH; k++) begin
      if (!shadow_cell_known[k]) return 1'b0;
      if (shadow_cell_col[k] > col) return 1'b1;
      if (shadow_cell_col[k] == col) begin
        answer.found = 1'b1;
        answer.value = shadow_cell_val[k];
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic srml_pkg::in_t filler_item();
    srml_pkg::in_t item;
    logic [31:0] word;
    word = $urandom;
    item.command = CMD_UNUSED;
    item.row = word[srml_pkg::ROW_W-1:0];
    item.row_is_empty = word[10];
    item.cell_index = word[srml_pkg::SLOT_W+10:11];
    item.column = word[31:16];
    item.cell_data = {$urandom, $urandom};
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Entered and left just after a falling edge.
  task automatic send_item(input srml_pkg::in_t item);
    srml_pkg::out_t answer;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (item.command)
      srml_pkg::CMD_ROW_WRITE: begin
        shadow_row_start[item.row] = item.cell_index;
        shadow_row_void[item.row] = item.row_is_empty;
        shadow_row_known[item.row] = 1'b1;
      end
      srml_pkg::CMD_CELL_WRITE: begin
        shadow_cell_col[item.cell_index] = item.column;
        shadow_cell_val[item.cell_index] = item.cell_data;
        shadow_cell_known[item.cell_index] = 1'b1;
      end
      srml_pkg::CMD_QUERY: begin
        void'(lookup_element(item.row, item.column, answer));
        pending_lookups.push_back(answer);
      end
      default: ;
    endcase
    if (item.command != CMD_UNUSED) items_issued++;
    @(negedge clk);
  endtask

  task automatic send_row(input int r, input bit empty, input int start);
    srml_pkg::in_t item;
    item = filler_item();
    item.command = srml_pkg::CMD_ROW_WRITE;
    item.row = r[srml_pkg::ROW_W-1:0];
    item.row_is_empty = empty;
    item.cell_index = start[srml_pkg::SLOT_W-1:0];
    send_item(item);
  endtask

  task automatic send_cell(input int slot, input int col,
                           input logic [srml_pkg::VALUE_W-1:0] data);
    srml_pkg::in_t item;
    item = filler_item();
    item.command = srml_pkg::CMD_CELL_WRITE;
    item.cell_index = slot[srml_pkg::SLOT_W-1:0];
    item.column = col[srml_pkg::COL_W-1:0];
    item.cell_data = data;
    send_item(item);
  endtask

  // Queries that would read a never-written entry are dropped.
  task automatic send_query(input int r, input int col);
    srml_pkg::in_t item;
    srml_pkg::out_t answer;
    if (!lookup_element(r[srml_pkg::ROW_W-1:0], col[srml_pkg::COL_W-1:0], answer)) return;
    item = filler_item();
    item.command = srml_pkg::CMD_QUERY;
    item.row = r[srml_pkg::ROW_W-1:0];
    item.column = col[srml_pkg::COL_W-1:0];
    send_item(item);
  endtask

  // Waits until every answer is back and any trailing write has been absorbed.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic set_dimensions(input logic [srml_pkg::CFG_DATA_W-1:0] rows_word,
                                input logic [srml_pkg::CFG_DATA_W-1:0] cells_word);
    cfg_we <= 1'b1;
    cfg_index <= srml_pkg::REG_ROW_COUNT;
    cfg_data <= rows_word;
    @(negedge clk);
    cfg_index <= srml_pkg::REG_CELL_COUNT;
    cfg_data <= cells_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_row_count = rows_word[srml_pkg::ROW_COUNT_W-1:0];
    shadow_cell_count = cells_word[srml_pkg::CELL_COUNT_W-1:0];
  endtask

  task automatic test_after_reset();
    send_query(1023, 65535);
  endtask

  task automatic test_small_matrix();
    settle();
    set_dimensions(13'd3, 13'd3);
    send_row(0, 1'b0, 0);
    send_row(1, 1'b1, 4095);
    send_row(2, 1'b0, 3);
    send_cell(0, 0, 64'h0);
    send_cell(1, 5, '1);
    send_cell(2, 65535, 64'h8000_0000_0000_0001);
    send_query(0, 5);
    send_query(0, 65535);
    send_query(0, 0);
    send_query(0, 3);
    send_query(1, 5);
    // Row 2 starts at the cell count, so it holds no cells.
    send_query(2, 0);
    send_query(3, 0);
    send_item('1);
  endtask

  task automatic test_trailing_empty_rows();
    send_row(2, 1'b1, 3);
    send_query(0, 65535);
    send_query(0, 65534);
    send_query(2, 65535);
  endtask

  task automatic test_full_size();
    int k;
    settle();
    // All-ones words exceed both memory depths, so the row and cell counts clamp to them.
    set_dimensions('1, '1);
    send_row(1020, 1'b0, 4093);
    for (k = 1021; k < ROW_DEPTH; k++) send_row(k, 1'b1, 4095);
    send_cell(4093, 100, 64'h0123_4567_89ab_cdef);
    send_cell(4094, 200, '1);
    send_cell(4095, 65534, 64'hfedc_ba98_7654_3210);
    send_query(1020, 65534);
    send_query(1020, 65535);
    send_query(1023, 65535);
  endtask

  task automatic test_zero_dimensions();
    settle();
    set_dimensions(13'd0, 13'd0);
    send_query(0, 0);
  endtask

  task automatic run_random_phase(input int rows_n, input int max_per_row, input int query_n);
    int slot;
    int r;
    int j;
    int col;
    int pick;
    int rows_word;
    int cells_word;
    logic [31:0] word;
    settle();
    slot = 0;
    for (r = 0; r < rows_n; r++) begin
      layout_first[r] = slot;
      layout_len[r] = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(max_per_row));
      if (layout_len[r] > 0) slot += layout_len[r];
    end
    case ($urandom_range(7))
      0: cells_word = slot + int'($urandom_range(3));
      1: cells_word = (slot > 0) ? int'($urandom_range(slot - 1)) : 0;
      default: cells_word = slot;
    endcase
    rows_word = ($urandom_range(5) == 0) ? int'($urandom_range(rows_n)) : rows_n;
    set_dimensions(rows_word[srml_pkg::CFG_DATA_W-1:0], cells_word[srml_pkg::CFG_DATA_W-1:0]);

    for (r = 0; r < rows_n; r++) begin
      if (layout_len[r] < 0) begin
        send_row(r, 1'b1, $urandom_range(4095));
      end else begin
        send_row(r, 1'b0, layout_first[r]);
        col = ($urandom_range(1) == 0) ? int'($urandom_range(40)) : int'($urandom_range(40000));
        for (j = 0; j < layout_len[r]; j++) begin
          send_cell(layout_first[r] + j, col, {$urandom, $urandom});
          col += $urandom_range(1, 3000);
        end
      end
    end

    // Mostly lookups of stored or neighboring columns, with some noise.
    for (j = 0; j < query_n; j++) begin
      pick = $urandom_range(19);
      r = $urandom_range(rows_n - 1);
      word = $urandom;
      if (pick < 12 && layout_len[r] > 0) begin
        col = shadow_cell_col[layout_first[r] + $urandom_range(layout_len[r] - 1)];
        if (pick >= 9) col = word[0] ? col + 1 : col - 1;
        send_query(r, col);
      end else if (pick < 15) begin
        send_query(r, word[15:0]);
      end else if (pick == 15) begin
        send_query(word[srml_pkg::ROW_W-1:0], word[31:16]);
      end else if (pick == 16) begin
        send_item(filler_item());
      end else if (pick == 17 && slot > 0) begin
        send_cell($urandom_range(slot - 1), word[15:0], {$urandom, $urandom});
      end else if (pick == 18) begin
        send_row(r, word[16], $urandom_range(slot));
      end else begin
        send_query(r, word[31:16]);
      end
    end
  endtask

  task automatic test_random_traffic(input int send_gap, input int recv_stall, input int item_goal);
    int goal;
    send_gap_pct = send_gap;
    recv_stall_pct = recv_stall;
    goal = items_issued + item_goal;
    while (items_issued < goal) begin
      if ($urandom_range(7) == 0)
        run_random_phase($urandom_range(40, 80), 3, $urandom_range(30, 60));
      else
        run_random_phase($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(20, 60));
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result with no query pending: found=%0b value=%h",
                                  out_data.found, out_data.value));
      end else begin
        oldest_answer = pending_lookups.pop_front();
        if (out_data.found !== oldest_answer.found)
          report_mismatch($sformatf("found=%0b, expected %0b",
                                    out_data.found, oldest_answer.found));
        if (out_data.value !== oldest_answer.value)
          report_mismatch($sformatf("value=%h, expected %h",
                                    out_data.value, oldest_answer.value));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_small_matrix();
    test_trailing_empty_rows();
    test_full_size();
    test_zero_dimensions();
    test_random_traffic(16, 47, 300);
    test_random_traffic(47, 16, 300);
    test_random_traffic(0, 0, 300);
    settle();
    repeat (32) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
